/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the transmitter RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RFDTX_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RFDTX_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rfdtx_pkg.sv */
// Package for the RF dongle frame transmitter: item/result types, phase codes,
// code tables and frame constants. No dependencies.
`default_nettype none

package rfdtx_pkg;

    localparam int unsigned FRAME_BITS = 40;
    localparam int unsigned POS_W      = 6;

    localparam logic [15:0] FRAME_HEADER = 16'hD5AA;
    localparam logic [7:0]  FRAME_FOOTER = 8'hAD;

    localparam logic [7:0]  BIT_TICKS_RST  = 8'd1;
    localparam logic [7:0]  SETTLE_RST     = 8'd35;
    localparam logic [7:0]  POST_WAIT_RST  = 8'd100;

    // configuration register indexes
    localparam logic [1:0] REG_BIT_TICKS  = 2'd0;
    localparam logic [1:0] REG_SETTLE     = 2'd1;
    localparam logic [1:0] REG_POST_WAIT  = 2'd2;

    // operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // commands
    localparam logic [1:0] CMD_ON     = 2'd0;
    localparam logic [1:0] CMD_OFF    = 2'd1;
    localparam logic [1:0] CMD_BRIGHT = 2'd2;
    localparam logic [1:0] CMD_DIM    = 2'd3;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_RST1   = 3'd1;
    localparam logic [2:0] PH_SETTLE = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_WAIT   = 3'd4;
    localparam logic [2:0] PH_POST   = 3'd5;
    localparam logic [2:0] PH_RST2   = 3'd6;

    typedef struct packed {
        logic       operation;
        logic [3:0] house_index;
        logic [3:0] device_index;
        logic [1:0] command;
        logic [7:0] repeat_count;
    } item_t;

    typedef struct packed {
        logic        rts_level;
        logic        dtr_level;
        logic        busy_res;
        logic        frame_done;
        logic        command_rejected;
        logic [31:0] frames_sent;
    } result_t;

    function automatic logic [15:0] house_code(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'h6000;
            4'd1:    c = 16'h7000;
            4'd2:    c = 16'h4000;
            4'd3:    c = 16'h5000;
            4'd4:    c = 16'h8000;
            4'd5:    c = 16'h9000;
            4'd6:    c = 16'hA000;
            4'd7:    c = 16'hB000;
            4'd8:    c = 16'hE000;
            4'd9:    c = 16'hF000;
            4'd10:   c = 16'hC000;
            4'd11:   c = 16'hD000;
            4'd12:   c = 16'h0000;
            4'd13:   c = 16'h1000;
            4'd14:   c = 16'h2000;
            4'd15:   c = 16'h3000;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] device_code(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'h0010;
            4'd2:    c = 16'h0008;
            4'd3:    c = 16'h0018;
            4'd4:    c = 16'h0040;
            4'd5:    c = 16'h0050;
            4'd6:    c = 16'h0048;
            4'd7:    c = 16'h0058;
            4'd8:    c = 16'h0400;
            4'd9:    c = 16'h0410;
            4'd10:   c = 16'h0408;
            4'd11:   c = 16'h0418;
            4'd12:   c = 16'h0440;
            4'd13:   c = 16'h0450;
            4'd14:   c = 16'h0448;
            4'd15:   c = 16'h0458;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] command_code(input logic [1:0] cmd);
        logic [15:0] c;
        case (cmd)
            CMD_ON:     c = 16'h0000;
            CMD_OFF:    c = 16'h0020;
            CMD_BRIGHT: c = 16'h0088;
            CMD_DIM:    c = 16'h0098;
            default:    c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rfdtx_step.sv */
// Phase sequencer of the transmitter: config registers, frame state and the
// per-transaction next-state/result logic. Depends on rfdtx_pkg, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rfdtx_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              write_enable,
    input  logic [1:0]        reg_index,
    input  logic [7:0]        write_data,
    input  logic              accept,
    input  rfdtx_pkg::item_t  item,
    output rfdtx_pkg::result_t result
);
    import rfdtx_pkg::*;

    logic [7:0]            bit_ticks_reg;
    logic [7:0]            settle_reg;
    logic [7:0]            post_wait_reg;

    logic [2:0]            phase_reg, phase_next;
    logic [7:0]            ticks_reg, ticks_next;
    logic [POS_W-1:0]      bitpos_reg, bitpos_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [8:0]            sends_reg, sends_next;
    logic [31:0]           count_reg, count_next;

    logic [7:0]            bit_len;
    logic [7:0]            t_dec;
    logic [8:0]            s_dec;
    logic [15:0]           data_word;
    logic                  done;
    logic                  rejected;
    logic [POS_W-1:0]      bit_sel;
    logic                  cur_bit;

    assign bit_len = (bit_ticks_reg == 8'd0) ? 8'd1 : bit_ticks_reg;
    assign t_dec   = (ticks_reg != 8'd0) ? ticks_reg - 8'd1 : 8'd0;
    assign s_dec   = (sends_reg != 9'd0) ? sends_reg - 9'd1 : 9'd0;

    always_comb
    begin
        data_word = house_code(item.house_index) | command_code(item.command);
        if (item.command inside {CMD_ON, CMD_OFF})
        begin
            data_word = data_word | device_code(item.device_index);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        bitpos_next = bitpos_reg;
        frame_next  = frame_reg;
        sends_next  = sends_reg;
        count_next  = count_reg;
        done        = 1'b0;
        rejected    = 1'b0;

        if (item.operation == OP_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                frame_next  = {FRAME_HEADER, data_word, FRAME_FOOTER};
                sends_next  = {1'b0, item.repeat_count} + 9'd1;
                count_next  = count_reg + 32'd1;
                bitpos_next = '0;
                phase_next  = PH_RST1;
                ticks_next  = bit_len;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            ticks_next = t_dec;
            if (t_dec == 8'd0)
            begin
                ticks_next = bit_len;
                case (phase_reg)
                    PH_RST1:
                    begin
                        if (settle_reg != 8'd0)
                        begin
                            phase_next = PH_SETTLE;
                            ticks_next = settle_reg;
                        end
                        else
                        begin
                            // no settle time: straight to the first bit
                            bitpos_next = '0;
                            phase_next  = PH_DATA;
                        end
                    end
                    PH_SETTLE:
                    begin
                        bitpos_next = '0;
                        phase_next  = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        phase_next = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        if (bitpos_reg != POS_W'(FRAME_BITS - 1))
                        begin
                            bitpos_next = bitpos_reg + POS_W'(1);
                            phase_next  = PH_DATA;
                        end
                        else if (post_wait_reg != 8'd0)
                        begin
                            phase_next = PH_POST;
                            ticks_next = post_wait_reg;
                        end
                        else
                        begin
                            phase_next = PH_RST2;
                        end
                    end
                    PH_POST:
                    begin
                        phase_next = PH_RST2;
                    end
                    default:
                    begin
                        // end of frame; restart if sends remain
                        done       = 1'b1;
                        sends_next = s_dec;
                        if (s_dec != 9'd0)
                        begin
                            count_next  = count_reg + 32'd1;
                            bitpos_next = '0;
                            phase_next  = PH_RST1;
                        end
                        else
                        begin
                            phase_next  = PH_IDLE;
                            ticks_next  = 8'd0;
                            bitpos_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    assign bit_sel = POS_W'(FRAME_BITS - 1) - bitpos_next;
    assign cur_bit = frame_next[bit_sel];

    always_comb
    begin
        result.rts_level        = 1'b0;
        result.dtr_level        = 1'b0;
        if (phase_next inside {PH_SETTLE, PH_WAIT, PH_POST})
        begin
            result.rts_level = 1'b1;
            result.dtr_level = 1'b1;
        end
        else if (phase_next == PH_DATA)
        begin
            result.rts_level = cur_bit;
            result.dtr_level = ~cur_bit;
        end
        result.busy_res         = (phase_next != PH_IDLE);
        result.frame_done       = done;
        result.command_rejected = rejected;
        result.frames_sent      = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= BIT_TICKS_RST;
            settle_reg    <= SETTLE_RST;
            post_wait_reg <= POST_WAIT_RST;
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_BIT_TICKS: bit_ticks_reg <= write_data;
                REG_SETTLE:    settle_reg    <= write_data;
                REG_POST_WAIT: post_wait_reg <= write_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ticks_reg  <= 8'd0;
            bitpos_reg <= '0;
            frame_reg  <= '0;
            sends_reg  <= 9'd0;
            count_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            bitpos_reg <= bitpos_next;
            frame_reg  <= frame_next;
            sends_reg  <= sends_next;
            count_reg  <= count_next;
        end
    end

    `RFDTX_ASSERT_ALWAYS(a_busy_has_ticks, (phase_reg != PH_IDLE) |-> (ticks_reg != 8'd0), "active phase with zero ticks")
    `RFDTX_ASSERT(a_bitpos_range, bitpos_reg < POS_W'(FRAME_BITS), "bit position past frame end")
    `RFDTX_ASSERT(a_idle_no_sends, (phase_reg == PH_IDLE) |-> (sends_reg == 9'd0), "idle with sends pending")

endmodule

`default_nettype wire

/* hw/rtl/rfdtx_obuf.sv */
// Two-entry result buffer (output register plus skid register) between the
// sequencer and the result channel. Depends on rfdtx_pkg, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rfdtx_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rfdtx_pkg::result_t push_data,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output rfdtx_pkg::result_t out_data
);
    import rfdtx_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    `RFDTX_ASSERT_ALWAYS(a_skid_needs_main, skid_valid_reg |-> main_valid_reg, "skid full, output empty")
    `RFDTX_ASSERT(a_main_holds, (main_valid_reg && !out_ready) |=> main_valid_reg, "result lost")
    `RFDTX_ASSERT(a_full_drain, (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg), "skid not drained")

endmodule

`default_nettype wire

/* hw/rtl/x10_rf_dongle_frame_transmitter_core.sv */
// Top level of the two-line RF dongle frame transmitter.
// Instantiates rfdtx_step and rfdtx_obuf; uses rfdtx_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  command   | in_valid / in_ready  | operation, house_index, device_index,
//            |                      | command, repeat_count
//  result    | out_valid / out_ready| rts_level, dtr_level, busy_res, frame_done,
//            |                      | command_rejected, frames_sent
//  config    | write_enable         | reg_index, write_data
//
// One transaction per clock while in_ready is high; the result goes to the output buffer.
// The sequencer's next state is combinational; a two-entry output buffer sets throughput.
// in_ready is low whenever both output entries are full, whatever out_ready is.
// Reset (async, active low) clears state; config registers return to 1/35/100 ticks.
`default_nettype none

module x10_rf_dongle_frame_transmitter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_enable,
    input  logic [1:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [3:0]  house_index,
    input  logic [3:0]  device_index,
    input  logic [1:0]  command,
    input  logic [7:0]  repeat_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        rts_level,
    output logic        dtr_level,
    output logic        busy_res,
    output logic        frame_done,
    output logic        command_rejected,
    output logic [31:0] frames_sent
);
    import rfdtx_pkg::*;

    item_t   item;
    result_t step_res;
    result_t out_res;
    logic    accept;
    logic    can_push;

    assign item.operation    = operation;
    assign item.house_index  = house_index;
    assign item.device_index = device_index;
    assign item.command      = command;
    assign item.repeat_count = repeat_count;

    assign in_ready = can_push;
    assign accept   = in_valid && can_push;

    rfdtx_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .accept       (accept),
        .item         (item),
        .result       (step_res)
    );

    rfdtx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign rts_level        = out_res.rts_level;
    assign dtr_level        = out_res.dtr_level;
    assign busy_res         = out_res.busy_res;
    assign frame_done       = out_res.frame_done;
    assign command_rejected = out_res.command_rejected;
    assign frames_sent      = out_res.frames_sent;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the two-line RF dongle frame transmitter.
// Holds a cycle-free predictor of the frame sequencer and checks every result
// transaction against it. Depends on rfdtx_pkg and the core top level only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfdtx_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // code tables, entry i at bit offset i*width
    localparam logic [63:0]    HOUSE_NIBS  = 64'h3210_DCFE_BA98_5476;
    localparam logic [255:0]   DEVICE_BITS = {16'h0458, 16'h0448, 16'h0450, 16'h0440,
                                              16'h0418, 16'h0408, 16'h0410, 16'h0400,
                                              16'h0058, 16'h0048, 16'h0050, 16'h0040,
                                              16'h0018, 16'h0008, 16'h0010, 16'h0000};
    localparam logic [63:0]    CMD_BITS    = {16'h0098, 16'h0088, 16'h0020, 16'h0000};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        write_enable = 1'b0;
    logic [1:0]  reg_index = '0;
    logic [7:0]  write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [3:0]  house_index = '0;
    logic [3:0]  device_index = '0;
    logic [1:0]  command = '0;
    logic [7:0]  repeat_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        rts_level;
    logic        dtr_level;
    logic        busy_res;
    logic        frame_done;
    logic        command_rejected;
    logic [31:0] frames_sent;

    x10_rf_dongle_frame_transmitter_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .write_enable     (write_enable),
        .reg_index        (reg_index),
        .write_data       (write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .house_index      (house_index),
        .device_index     (device_index),
        .command          (command),
        .repeat_count     (repeat_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .rts_level        (rts_level),
        .dtr_level        (dtr_level),
        .busy_res         (busy_res),
        .frame_done       (frame_done),
        .command_rejected (command_rejected),
        .frames_sent      (frames_sent)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------- sequencer predictor ----------------
    logic [7:0]  cfg_bit, cfg_settle, cfg_post;
    logic [2:0]  tx_phase;
    logic [7:0]  tx_ticks;
    logic [5:0]  tx_bitpos;
    logic [39:0] tx_shift;
    logic [8:0]  tx_sends;
    logic [31:0] tx_frames;

    result_t     line_state_q[$];
    result_t     want;
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_frames_done = 0;
    int          n_rejected = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          steady = 1'b0;

    function automatic void load_phase(input logic [2:0] p);
        logic [7:0] n;
        bit         searching;
        searching = 1'b1;
        while (searching)
        begin
            tx_phase = p;
            if (p == PH_SETTLE)
                n = cfg_settle;
            else if (p == PH_POST)
                n = cfg_post;
            else
                n = (cfg_bit == 8'd0) ? 8'd1 : cfg_bit;
            if (n != 8'd0)
            begin
                tx_ticks  = n;
                searching = 1'b0;
            end
            else if (p == PH_SETTLE)
            begin
                tx_bitpos = '0;
                p = PH_DATA;
            end
            else
                p = PH_RST2;
        end
    endfunction

    function automatic void begin_frame();
        tx_frames = tx_frames + 32'd1;
        tx_bitpos = '0;
        load_phase(PH_RST1);
    endfunction

    // returns 1 when the closing reset of a frame ran out
    function automatic logic finish_phase();
        logic done;
        done = 1'b0;
        case (tx_phase)
            PH_RST1:   load_phase(PH_SETTLE);
            PH_SETTLE:
            begin
                tx_bitpos = '0;
                load_phase(PH_DATA);
            end
            PH_DATA:   load_phase(PH_WAIT);
            PH_WAIT:
            begin
                if (tx_bitpos + 1 < FRAME_BITS)
                begin
                    tx_bitpos = tx_bitpos + 6'd1;
                    load_phase(PH_DATA);
                end
                else
                    load_phase(PH_POST);
            end
            PH_POST:   load_phase(PH_RST2);
            default:
            begin
                if (tx_sends != 9'd0)
                    tx_sends = tx_sends - 9'd1;
                if (tx_sends != 9'd0)
                    begin_frame();
                else
                begin
                    tx_phase  = PH_IDLE;
                    tx_ticks  = '0;
                    tx_bitpos = '0;
                end
                done = 1'b1;
            end
        endcase
        return done;
    endfunction

    function automatic result_t predict_lines(input item_t it);
        result_t     r;
        logic [15:0] word;
        r = '0;
        if (it.operation == OP_START)
        begin
            if (tx_phase != PH_IDLE)
                r.command_rejected = 1'b1;
            else
            begin
                word = {HOUSE_NIBS[it.house_index*4 +: 4], 12'h000}
                     | CMD_BITS[it.command*16 +: 16];
                // bright and dim carry no device code
                if (it.command == CMD_ON || it.command == CMD_OFF)
                    word = word | DEVICE_BITS[it.device_index*16 +: 16];
                tx_shift = {FRAME_HEADER, word, FRAME_FOOTER};
                tx_sends = {1'b0, it.repeat_count} + 9'd1;
                begin_frame();
            end
        end
        else if (tx_phase != PH_IDLE)
        begin
            if (tx_ticks != 8'd0)
                tx_ticks = tx_ticks - 8'd1;
            if (tx_ticks == 8'd0)
                r.frame_done = finish_phase();
        end
        if (tx_phase == PH_SETTLE || tx_phase == PH_WAIT || tx_phase == PH_POST)
        begin
            r.rts_level = 1'b1;
            r.dtr_level = 1'b1;
        end
        else if (tx_phase == PH_DATA)
        begin
            r.rts_level = tx_shift[FRAME_BITS - 1 - tx_bitpos];
            r.dtr_level = ~r.rts_level;
        end
        r.busy_res    = (tx_phase != PH_IDLE);
        r.frames_sent = tx_frames;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = rand_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation    = it.operation;
        house_index  = it.house_index;
        device_index = it.device_index;
        command      = it.command;
        repeat_count = it.repeat_count;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        line_state_q.push_back(predict_lines(it));
        n_items++;
    endtask

    task automatic send_tick();
        item_t it;
        it = item_t'($urandom());
        it.operation = OP_TICK;
        send_item(it);
    endtask

    task automatic send_cmd(input logic [3:0] h, input logic [3:0] d,
                            input logic [1:0] c, input logic [7:0] rep);
        item_t it;
        it.operation    = OP_START;
        it.house_index  = h;
        it.device_index = d;
        it.command      = c;
        it.repeat_count = rep;
        send_item(it);
    endtask

    task automatic run_to_idle();
        while (tx_phase != PH_IDLE)
            send_tick();
    endtask

    // drop valid and let every outstanding result come back
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (line_state_q.size() > 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain_results();
        write_enable = 1'b1;
        reg_index    = idx;
        write_data   = val;
        @(negedge clk);
        write_enable = 1'b0;
        case (idx)
            REG_BIT_TICKS: cfg_bit    = val;
            REG_SETTLE:    cfg_settle = val;
            REG_POST_WAIT: cfg_post   = val;
            default:       ;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] b, input logic [7:0] s, input logic [7:0] p);
        write_reg(REG_BIT_TICKS, b);
        write_reg(REG_SETTLE, s);
        write_reg(REG_POST_WAIT, p);
    endtask

    // ---------------- tests ----------------
    task automatic test_idle_ticks();
        item_t it;
        repeat (3) send_tick();
        it = '1;
        it.operation = OP_TICK;
        send_item(it);
    endtask

    task automatic test_default_timing();
        send_cmd(4'd0, 4'd0, CMD_ON, 8'd0);
        run_to_idle();
    endtask

    task automatic test_command_codes();
        set_timing(8'd1, 8'd0, 8'd0);
        send_cmd(4'd15, 4'd15, CMD_OFF, 8'd0);
        send_cmd(4'd15, 4'd15, CMD_ON, 8'd255);     // busy, must be dropped
        run_to_idle();
    endtask

    task automatic test_long_repeat();
        int k;
        set_timing(8'd1, 8'd0, 8'd0);
        send_cmd(4'd5, 4'd9, CMD_BRIGHT, 8'd1);
        k = 0;
        while (tx_phase != PH_IDLE)
        begin
            k++;
            if (k % 50 == 0)
                send_cmd(4'($urandom()), 4'($urandom()), 2'($urandom()), 8'($urandom()));
            else
                send_tick();
        end
    endtask

    task automatic test_zero_bit_ticks();
        set_timing(8'd0, 8'd1, 8'd1);
        write_reg(2'd3, 8'hFF);                      // unmapped index
        send_cmd(4'd10, 4'd6, CMD_DIM, 8'd0);
        run_to_idle();
    endtask

    task automatic test_midframe_reconfig();
        set_timing(8'd2, 8'd3, 8'd4);
        send_cmd(4'd12, 4'd7, CMD_OFF, 8'd0);
        repeat (30) send_tick();
        set_timing(8'd1, 8'd0, 8'd9);
        run_to_idle();
    endtask

    task automatic test_random_traffic(input int n_per_phase);
        item_t it;
        int    ph_i;
        int    i;
        for (ph_i = 0; ph_i < 4; ph_i++)
        begin
            if ($urandom_range(0, 99) < 70)
                set_timing(8'($urandom_range(1, 3)), 8'($urandom_range(0, 8)),
                           8'($urandom_range(0, 8)));
            else
                set_timing(8'($urandom_range(0, 4)), 8'($urandom()), 8'($urandom()));
            steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n_per_phase; i++)
            begin
                it = item_t'($urandom());
                if ((tx_phase == PH_IDLE && $urandom_range(0, 99) < 40) ||
                    $urandom_range(0, 99) < 4)
                begin
                    it.operation = OP_START;
                    if ($urandom_range(0, 99) < 80)
                        it.repeat_count = 8'($urandom_range(0, 2));
                end
                else
                    it.operation = OP_TICK;
                send_item(it);
            end
            steady = 1'b0;
        end
    endtask

    // ---------------- result side ----------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (line_state_q.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                errors++;
            end
            else
            begin
                want = line_state_q.pop_front();
                if (want.frame_done)
                    n_frames_done++;
                if (want.command_rejected)
                    n_rejected++;
                cmp_field("rts_level", want.rts_level, rts_level);
                cmp_field("dtr_level", want.dtr_level, dtr_level);
                cmp_field("busy_res", want.busy_res, busy_res);
                cmp_field("frame_done", want.frame_done, frame_done);
                cmp_field("command_rejected", want.command_rejected, command_rejected);
                cmp_field("frames_sent", want.frames_sent, frames_sent);
            end
        end
    end

    // watchdog on cycles without any accepted command or result transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_bit    = BIT_TICKS_RST;
        cfg_settle = SETTLE_RST;
        cfg_post   = POST_WAIT_RST;
        tx_phase   = PH_IDLE;
        tx_ticks   = '0;
        tx_bitpos  = '0;
        tx_shift   = '0;
        tx_sends   = '0;
        tx_frames  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_ticks();
        test_default_timing();
        test_command_codes();
        test_long_repeat();
        test_zero_bit_ticks();
        test_midframe_reconfig();
        test_random_traffic(50);

        drain_results();
        repeat (5) @(negedge clk);
        if (line_state_q.size() != 0)
        begin
            $error("%0d expected results never arrived", line_state_q.size());
            errors++;
        end
        $display("tb: %0d transactions in, %0d results checked, %0d mismatches",
                 n_items, n_results, errors);
        $display("tb: %0d frames completed, %0d busy commands dropped, %0d frames started",
                 n_frames_done, n_rejected, tx_frames);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rfdtx_pkg.sv
hw/rtl/rfdtx_step.sv
hw/rtl/rfdtx_obuf.sv
hw/rtl/x10_rf_dongle_frame_transmitter_core.sv
dv/testbench.sv
